FILE: src/order_table_with_volume_totals_core_assert.svh
// Assertion macros for the order table core.
`ifndef ORDER_TABLE_WITH_VOLUME_TOTALS_CORE_ASSERT_SVH
`define ORDER_TABLE_WITH_VOLUME_TOTALS_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define OTVT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);
`define OTVT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);
`else
`define OTVT_ASSERT_SAME(lbl, ante, cons, msg)
`define OTVT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: src/otvt_pkg.sv
// Shared types and constants for the order table core.
package otvt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 32;
    localparam int QTY_W       = 32;
    localparam int TOT_W       = 40;
    localparam int ECNT_W      = 7;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 88;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_DUP     = 2'd1,
        STS_MISSING = 2'd2,
        STS_FULL    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              closed;
        logic [QTY_W-1:0]  qty;
        logic [ID_W-1:0]   id;
    } t_entry;

    typedef struct packed {
        logic              clr;
        logic              add;
        logic              closed;
        logic [QTY_W-1:0]  qty;
    } t_acc_ctl;

endpackage

FILE: src/otvt_table_mem.sv
// Order table storage: one write port, one registered read port.
module otvt_table_mem (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [otvt_pkg::IDX_W-1:0]  i_waddr,
    input  otvt_pkg::t_entry            i_wdata,
    input  logic [otvt_pkg::IDX_W-1:0]  i_raddr,
    output otvt_pkg::t_entry            o_rdata
);

    otvt_pkg::t_entry r_mem [otvt_pkg::TABLE_DEPTH];
    otvt_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/otvt_accum.sv
// Saturating accumulators for the total and outstanding volumes.
module otvt_accum (
    input  logic                        i_clk,
    input  otvt_pkg::t_acc_ctl          i_ctl,
    output logic [otvt_pkg::TOT_W-1:0]  o_total,
    output logic [otvt_pkg::TOT_W-1:0]  o_outstanding
);

    logic [otvt_pkg::TOT_W-1:0] r_total;
    logic [otvt_pkg::TOT_W-1:0] r_outst;
    logic [otvt_pkg::TOT_W-1:0] n_total;
    logic [otvt_pkg::TOT_W-1:0] n_outst;
    logic [otvt_pkg::TOT_W:0]   sum_total;
    logic [otvt_pkg::TOT_W:0]   sum_outst;

    always_comb begin
        sum_total = {1'b0, r_total} + (otvt_pkg::TOT_W + 1)'(i_ctl.qty);
        sum_outst = {1'b0, r_outst} + (otvt_pkg::TOT_W + 1)'(i_ctl.qty);
        n_total   = r_total;
        n_outst   = r_outst;
        if (i_ctl.clr) begin
            n_total = '0;
            n_outst = '0;
        end else if (i_ctl.add) begin
            n_total = sum_total[otvt_pkg::TOT_W] ? '1 : sum_total[otvt_pkg::TOT_W-1:0];
            if (!i_ctl.closed) begin
                n_outst = sum_outst[otvt_pkg::TOT_W] ? '1 : sum_outst[otvt_pkg::TOT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= n_total;
        r_outst <= n_outst;
    end

    assign o_total       = r_total;
    assign o_outstanding = r_outst;

endmodule

FILE: src/otvt_seq.sv
// Command sequencer: scans the table one entry a cycle and updates it.
module otvt_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  otvt_pkg::t_cmd              i_cmd,
    input  otvt_pkg::t_entry            i_item,
    input  logic                        i_out_free,
    output logic                        o_ready,
    output logic                        o_done,
    output otvt_pkg::t_status           o_status,
    output logic [otvt_pkg::CNT_W-1:0]  o_count,
    output otvt_pkg::t_acc_ctl          o_acc
);

    otvt_pkg::t_state                r_state;
    otvt_pkg::t_state                n_state;
    otvt_pkg::t_cmd                  r_cmd;
    otvt_pkg::t_cmd                  n_cmd;
    otvt_pkg::t_entry                r_item;
    otvt_pkg::t_entry                n_item;
    otvt_pkg::t_status               r_status;
    otvt_pkg::t_status               n_status;
    logic [otvt_pkg::CNT_W-1:0]      r_count;
    logic [otvt_pkg::CNT_W-1:0]      n_count;
    logic [otvt_pkg::CNT_W-1:0]      r_ridx;
    logic [otvt_pkg::CNT_W-1:0]      n_ridx;
    logic [otvt_pkg::IDX_W-1:0]      r_pidx;
    logic [otvt_pkg::IDX_W-1:0]      n_pidx;
    logic                            r_pv;
    logic                            n_pv;
    logic                            r_found;
    logic                            n_found;

    logic                            accept;
    logic                            more;
    logic                            hit;
    logic                            mem_we;
    logic [otvt_pkg::IDX_W-1:0]      mem_waddr;
    otvt_pkg::t_entry                mem_wdata;
    otvt_pkg::t_entry                mem_rdata;

    otvt_table_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_ridx[otvt_pkg::IDX_W-1:0]),
        .o_rdata (mem_rdata)
    );

    assign accept = (r_state == otvt_pkg::S_IDLE) && i_valid;
    assign more   = r_ridx < r_count;
    assign hit    = ((r_cmd == otvt_pkg::CMD_ADD) || (r_cmd == otvt_pkg::CMD_DELETE))
                    && (mem_rdata.id == r_item.id);

    always_comb begin
        n_state = r_state;
        case (r_state)
            otvt_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = otvt_pkg::S_SCAN;
                end
            end
            otvt_pkg::S_SCAN: begin
                if (!more && !r_pv) begin
                    n_state = otvt_pkg::S_FINISH;
                end
            end
            otvt_pkg::S_FINISH: begin
                n_state = otvt_pkg::S_DONE;
            end
            otvt_pkg::S_DONE: begin
                if (i_out_free) begin
                    n_state = otvt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = otvt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_cmd     = r_cmd;
        n_item    = r_item;
        n_status  = r_status;
        n_count   = r_count;
        n_ridx    = r_ridx;
        n_pidx    = r_pidx;
        n_pv      = 1'b0;
        n_found   = r_found;
        mem_we    = 1'b0;
        mem_waddr = r_pidx - otvt_pkg::IDX_W'(1);
        mem_wdata = mem_rdata;
        o_acc     = '{clr: 1'b0, add: 1'b0, closed: mem_rdata.closed, qty: mem_rdata.qty};
        o_done    = 1'b0;
        case (r_state)
            otvt_pkg::S_IDLE: begin
                if (accept) begin
                    n_cmd     = i_cmd;
                    n_item    = i_item;
                    n_ridx    = '0;
                    n_found   = 1'b0;
                    n_status  = otvt_pkg::STS_OK;
                    o_acc.clr = 1'b1;
                    if (i_cmd == otvt_pkg::CMD_CLEAR) begin
                        n_count = '0;
                    end
                end
            end
            otvt_pkg::S_SCAN: begin
                if (more) begin
                    n_ridx = r_ridx + otvt_pkg::CNT_W'(1);
                    n_pidx = r_ridx[otvt_pkg::IDX_W-1:0];
                    n_pv   = 1'b1;
                end
                if (r_pv) begin
                    n_found   = r_found || hit;
                    o_acc.add = !(hit && (r_cmd == otvt_pkg::CMD_DELETE));
                    mem_we    = (r_cmd == otvt_pkg::CMD_DELETE) && r_found;
                end
            end
            otvt_pkg::S_FINISH: begin
                case (r_cmd)
                    otvt_pkg::CMD_ADD: begin
                        if (r_found) begin
                            n_status = otvt_pkg::STS_DUP;
                        end else if (r_count >= otvt_pkg::CNT_W'(otvt_pkg::TABLE_DEPTH)) begin
                            n_status = otvt_pkg::STS_FULL;
                        end else begin
                            mem_we       = 1'b1;
                            mem_waddr    = r_count[otvt_pkg::IDX_W-1:0];
                            mem_wdata    = r_item;
                            o_acc.add    = 1'b1;
                            o_acc.closed = r_item.closed;
                            o_acc.qty    = r_item.qty;
                            n_count      = r_count + otvt_pkg::CNT_W'(1);
                        end
                    end
                    otvt_pkg::CMD_DELETE: begin
                        if (r_found) begin
                            n_count = r_count - otvt_pkg::CNT_W'(1);
                        end else begin
                            n_status = otvt_pkg::STS_MISSING;
                        end
                    end
                    default: begin
                        n_status = otvt_pkg::STS_OK;
                    end
                endcase
            end
            otvt_pkg::S_DONE: begin
                o_done = i_out_free;
            end
            default: begin
                o_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= otvt_pkg::S_IDLE;
            r_count <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pv    <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_item   <= n_item;
        r_status <= n_status;
        r_ridx   <= n_ridx;
        r_pidx   <= n_pidx;
        r_found  <= n_found;
    end

    assign o_ready  = (r_state == otvt_pkg::S_IDLE);
    assign o_status = r_status;
    assign o_count  = r_count;

endmodule

FILE: src/order_table_with_volume_totals_core.sv
// Order table with volume totals: top level with stream ports and result register.
// Each command scans the N entries held before it (none for clear), then
// writes its result; one command is in progress at a time. A waiting
// result does not block input but holds the next command in its final state.
// Reset: control state and entry count clear; table contents stay undefined.
`include "order_table_with_volume_totals_core_assert.svh"
module order_table_with_volume_totals_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // order_id[31:0], order_quantity[63:32], order_closed[64], zero pad
    input  logic [otvt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // command[1:0]
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // entry_count[6:0], total_volume[46:7], outstanding_volume[86:47], zero pad
    output logic [otvt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // status[1:0]
    output logic [1:0]                          m_axis_tuser
);

    logic                               seq_ready;
    logic                               seq_done;
    logic                               out_free;
    otvt_pkg::t_status                  seq_status;
    logic [otvt_pkg::CNT_W-1:0]         seq_count;
    otvt_pkg::t_acc_ctl                 acc_ctl;
    otvt_pkg::t_entry                   in_item;
    logic [otvt_pkg::TOT_W-1:0]         total;
    logic [otvt_pkg::TOT_W-1:0]         outstanding;

    logic                               r_out_valid;
    logic [otvt_pkg::OUT_DATA_W-1:0]    r_out_data;
    logic [1:0]                         r_out_user;

    assign in_item.id     = s_axis_tdata[31:0];
    assign in_item.qty    = s_axis_tdata[63:32];
    assign in_item.closed = s_axis_tdata[64];
    assign out_free       = !r_out_valid || m_axis_tready;

    otvt_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .i_cmd      (otvt_pkg::t_cmd'(s_axis_tuser)),
        .i_item     (in_item),
        .i_out_free (out_free),
        .o_ready    (seq_ready),
        .o_done     (seq_done),
        .o_status   (seq_status),
        .o_count    (seq_count),
        .o_acc      (acc_ctl)
    );

    otvt_accum u_accum (
        .i_clk         (i_clk),
        .i_ctl         (acc_ctl),
        .o_total       (total),
        .o_outstanding (outstanding)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done) begin
            r_out_data <= {(otvt_pkg::OUT_DATA_W - 2 * otvt_pkg::TOT_W - otvt_pkg::ECNT_W)'(0),
                           outstanding, total, otvt_pkg::ECNT_W'(seq_count)};
            r_out_user <= seq_status;
        end
    end

    assign s_axis_tready = seq_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    `OTVT_ASSERT_NEXT(a_busy_after_transfer, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while a command is in progress")
    `OTVT_ASSERT_SAME(a_no_overwrite, seq_done, out_free, "result register overwritten before transfer")
    `OTVT_ASSERT_SAME(a_count_bound, 1'b1, seq_count <= otvt_pkg::CNT_W'(otvt_pkg::TABLE_DEPTH), "entry count beyond table depth")
    `OTVT_ASSERT_SAME(a_totals_order, seq_done, outstanding <= total, "outstanding volume above total volume")

endmodule
